[rtl/goal_report_line_parser_macros.svh]
// ----------------------------------------------------------------------------
// goal report line parser assertion macros
// shared property shorthands for the goal report line parser checks
// ----------------------------------------------------------------------------
`ifndef GOAL_REPORT_LINE_PARSER_MACROS_SVH
`define GOAL_REPORT_LINE_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GRLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/grlp_pkg.sv]
// ----------------------------------------------------------------------------
// grlp_pkg
// shared types and character constants of the goal report line parser
// ----------------------------------------------------------------------------
package grlp_pkg;

    localparam int OUT_BITS = 16;

    typedef logic signed [OUT_BITS-1:0] t_val16;

    // characters of the report syntax
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h46;

    localparam logic [2:0] LEN_MIN    = 3'd5;
    localparam logic [2:0] FIELD_LAST = 3'd4;

    // a finished line as seen by the goal store
    typedef struct packed {
        logic   taken;
        logic   home;
        logic   front;
        t_val16 height;
        t_val16 x;
        t_val16 y;
    } t_line_event;

    // one goal as presented on the result side
    typedef struct packed {
        logic   seen;
        logic   front;
        t_val16 height;
        t_val16 x;
        t_val16 y;
    } t_goal;

endpackage

[rtl/goal_report_line_parser.sv]
// ----------------------------------------------------------------------------
// goal_report_line_parser
// goal report parser: UART bytes and millisecond ticks in, goal state out
// ----------------------------------------------------------------------------
// Each request is either one received UART byte or one millisecond tick, and
// each request yields exactly one result: the current view of both goals plus
// a flag saying whether this byte closed a line that updated a goal. Lines
// have the form type,orientation,height,x,y with type E (enemy) or H (home)
// and orientation F for front; numbers are parsed like atol and clamped to the
// signed VALUE_BITS range, then shown as their low 16 bits. A detection is
// dropped once more than timeout_ms ticks have passed since its last update.
// Throughput is one request per clock: the line state and goal store are
// updated in the cycle a request is accepted, the result lands in a single
// output register, and a new request is taken whenever that register is
// empty or being drained. Each result appears in the cycle after its request.
// The timeout register should only be written while no request is in flight.
// ----------------------------------------------------------------------------
module goal_report_line_parser #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [7:0]            i_byte_value,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_enemy_seen,
    output logic                  o_enemy_front,
    output grlp_pkg::t_val16      o_enemy_height,
    output grlp_pkg::t_val16      o_enemy_x,
    output grlp_pkg::t_val16      o_enemy_y,
    output logic                  o_home_seen,
    output logic                  o_home_front,
    output grlp_pkg::t_val16      o_home_height,
    output grlp_pkg::t_val16      o_home_x,
    output grlp_pkg::t_val16      o_home_y,
    output logic                  o_line_taken,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [31:0]           i_cfg_timeout_ms
);
    import grlp_pkg::*;

    `include "goal_report_line_parser_macros.svh"

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

    logic        in_acc;
    logic        byte_en;
    logic        tick;
    t_line_event ev;

    // goal store: index 0 is the enemy goal, index 1 the home goal
    logic        r_seen  [2];
    logic        r_front [2];
    t_val16      r_height[2];
    t_val16      r_x     [2];
    t_val16      r_y     [2];
    logic [31:0] r_age   [2];  // ticks since last update, modulo 2^32

    logic        n_seen  [2];
    logic        n_front [2];
    t_val16      n_height[2];
    t_val16      n_x     [2];
    t_val16      n_y     [2];
    logic [31:0] n_age   [2];

    logic [31:0] r_timeout;

    // result register
    logic        r_out_valid;
    t_goal       r_out_goal[2];
    logic        r_out_taken;

    // output register empty or draining this cycle
    assign o_ready     = !r_out_valid || i_ready;
    assign in_acc      = i_valid && o_ready;
    assign byte_en     = in_acc && !i_func;
    assign tick        = in_acc && i_func;
    assign o_cfg_ready = 1'b1;

    grlp_line_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_line_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_byte    (i_byte_value),
        .o_event   (ev)
    );

    // goal update and timeout check, per goal and independent of each other
    always_comb begin
        for (int g = 0; g < 2; g++) begin
            n_front[g]  = r_front[g];
            n_height[g] = r_height[g];
            n_x[g]      = r_x[g];
            n_y[g]      = r_y[g];
            n_age[g]    = tick ? (r_age[g] + 32'd1) : r_age[g];
            n_seen[g]   = r_seen[g];
            if (ev.taken && (ev.home == 1'(g))) begin
                n_seen[g]   = 1'b1;
                n_front[g]  = ev.front;
                n_height[g] = ev.height;
                n_x[g]      = ev.x;
                n_y[g]      = ev.y;
                n_age[g]    = '0;
            end
            // stale detections are dropped on every request
            if (n_age[g] > r_timeout) begin
                n_seen[g] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_timeout_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < 2; g++) begin
                r_seen[g]   <= 1'b0;
                r_front[g]  <= 1'b0;
                r_height[g] <= '0;
                r_x[g]      <= '0;
                r_y[g]      <= '0;
                r_age[g]    <= '0;
            end
        end else if (in_acc) begin
            for (int g = 0; g < 2; g++) begin
                r_seen[g]   <= n_seen[g];
                r_front[g]  <= n_front[g];
                r_height[g] <= n_height[g];
                r_x[g]      <= n_x[g];
                r_y[g]      <= n_y[g];
                r_age[g]    <= n_age[g];
            end
        end
    end

    // result register; payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int g = 0; g < 2; g++) begin
                r_out_goal[g].seen   <= n_seen[g];
                r_out_goal[g].front  <= n_seen[g] && n_front[g];
                r_out_goal[g].height <= n_height[g];
                r_out_goal[g].x      <= n_x[g];
                r_out_goal[g].y      <= n_y[g];
            end
            r_out_taken <= ev.taken;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_enemy_seen   = r_out_goal[0].seen;
    assign o_enemy_front  = r_out_goal[0].front;
    assign o_enemy_height = r_out_goal[0].height;
    assign o_enemy_x      = r_out_goal[0].x;
    assign o_enemy_y      = r_out_goal[0].y;
    assign o_home_seen    = r_out_goal[1].seen;
    assign o_home_front   = r_out_goal[1].front;
    assign o_home_height  = r_out_goal[1].height;
    assign o_home_x       = r_out_goal[1].x;
    assign o_home_y       = r_out_goal[1].y;
    assign o_line_taken   = r_out_taken;

    // a freshly taken line always leaves its goal detected
    `GRLP_ASSERT_NOW(a_taken_seen, i_clk, i_rst_n, o_valid && o_line_taken, o_enemy_seen || o_home_seen, "taken line without a detected goal")
    // an accepted request always produces a result next cycle
    `GRLP_ASSERT_NEXT(a_req_result, i_clk, i_rst_n, in_acc, r_out_valid, "accepted request produced no result")
    // taking an enemy line restarts its age
    `GRLP_ASSERT_NEXT(a_enemy_age, i_clk, i_rst_n, in_acc && ev.taken && !ev.home, r_age[0] == 32'd0, "enemy age not restarted")
    // ticks alone never mark a line as taken
    `GRLP_ASSERT_NEXT(a_tick_no_take, i_clk, i_rst_n, tick, !r_out_taken, "tick reported a taken line")

endmodule

[rtl/grlp_line_parse.sv]
// ----------------------------------------------------------------------------
// grlp_line_parse
// per-byte line tokeniser: type, orientation and three saturating numbers
// ----------------------------------------------------------------------------
module grlp_line_parse #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_en,
    input  logic [7:0]            i_byte,
    output grlp_pkg::t_line_event o_event
);
    import grlp_pkg::*;

    typedef enum logic [1:0] {PH_WS, PH_SIGN, PH_DIGITS, PH_DONE} t_phase;
    typedef enum logic [1:0] {LT_NONE, LT_ENEMY, LT_HOME} t_line_type;

    localparam logic [VALUE_BITS-1:0] LIM     = VALUE_BITS'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] POS_MAX = LIM - VALUE_BITS'(1);
    localparam logic [VALUE_BITS+3:0] LIM_W   = (VALUE_BITS + 4)'(LIM);

    logic [2:0]            r_len,     n_len;
    logic [2:0]            r_field,   n_field;
    t_line_type            r_type,    n_type;
    logic                  r_ended,   n_ended;
    logic                  r_decided, n_decided;
    logic                  r_front,   n_front;
    logic                  r_neg,     n_neg;
    t_phase                r_phase,   n_phase;
    logic [VALUE_BITS-1:0] r_mag,     n_mag;
    t_val16                r_acc_h,   n_acc_h;
    t_val16                r_acc_x,   n_acc_x;

    logic                         is_digit;
    logic                         is_ws;
    logic [3:0]                   digit;
    logic [VALUE_BITS+3:0]        mag_wide;
    logic signed [VALUE_BITS-1:0] val_full;
    t_val16                       num_val;

    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign is_ws    = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign digit    = 4'(i_byte - CH_0);
    assign mag_wide = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                    + (VALUE_BITS + 4)'(digit);

    // clamp to the signed range, then keep the low output bits
    assign val_full = r_neg ? signed'((~r_mag) + VALUE_BITS'(1))
                            : signed'((r_mag < LIM) ? r_mag : POS_MAX);
    assign num_val  = t_val16'(val_full);

    always_comb begin
        n_len     = r_len;
        n_field   = r_field;
        n_type    = r_type;
        n_ended   = r_ended;
        n_decided = r_decided;
        n_front   = r_front;
        n_neg     = r_neg;
        n_phase   = r_phase;
        n_mag     = r_mag;
        n_acc_h   = r_acc_h;
        n_acc_x   = r_acc_x;
        if (i_byte_en) begin
            if (i_byte == CH_LF) begin
                n_len     = '0;
                n_field   = '0;
                n_type    = LT_NONE;
                n_ended   = 1'b0;
                n_decided = 1'b0;
                n_front   = 1'b0;
                n_neg     = 1'b0;
                n_phase   = PH_WS;
                n_mag     = '0;
                n_acc_h   = '0;
                n_acc_x   = '0;
            end else begin
                if (r_len == 3'd0) begin
                    n_type = (i_byte == CH_E) ? LT_ENEMY :
                             (i_byte == CH_H) ? LT_HOME : LT_NONE;
                end
                if (r_len < LEN_MIN) begin
                    n_len = r_len + 3'd1;
                end
                if (!r_ended) begin
                    if (i_byte == CH_NUL) begin
                        n_ended = 1'b1;
                    end else begin
                        if (r_field == 3'd1 && !r_decided) begin
                            n_decided = 1'b1;
                            n_front   = (i_byte == CH_F);
                        end
                        if (i_byte == CH_COMMA && r_field < FIELD_LAST) begin
                            if (r_field == 3'd2) begin
                                n_acc_h = num_val;
                            end
                            if (r_field == 3'd3) begin
                                n_acc_x = num_val;
                            end
                            n_field = r_field + 3'd1;
                            n_mag   = '0;
                            n_neg   = 1'b0;
                            n_phase = PH_WS;
                        end else if (r_field >= 3'd2 && r_phase != PH_DONE) begin
                            priority if (is_digit) begin
                                n_mag   = (mag_wide > LIM_W) ? LIM : mag_wide[VALUE_BITS-1:0];
                                n_phase = PH_DIGITS;
                            end else if (r_phase == PH_WS && is_ws) begin
                                n_phase = PH_WS;
                            end else if (r_phase == PH_WS
                                         && (i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                                n_neg   = (i_byte == CH_MINUS);
                                n_phase = PH_SIGN;
                            end else begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_field   <= '0;
            r_type    <= LT_NONE;
            r_ended   <= 1'b0;
            r_decided <= 1'b0;
            r_front   <= 1'b0;
            r_neg     <= 1'b0;
            r_phase   <= PH_WS;
            r_mag     <= '0;
            r_acc_h   <= '0;
            r_acc_x   <= '0;
        end else begin
            r_len     <= n_len;
            r_field   <= n_field;
            r_type    <= n_type;
            r_ended   <= n_ended;
            r_decided <= n_decided;
            r_front   <= n_front;
            r_neg     <= n_neg;
            r_phase   <= n_phase;
            r_mag     <= n_mag;
            r_acc_h   <= n_acc_h;
            r_acc_x   <= n_acc_x;
        end
    end

    // a newline closes the line; it counts only when well formed
    assign o_event.taken  = i_byte_en && (i_byte == CH_LF) && (r_len >= LEN_MIN)
                          && (r_type != LT_NONE) && (r_field == FIELD_LAST);
    assign o_event.home   = (r_type == LT_HOME);
    assign o_event.front  = r_front;
    assign o_event.height = r_acc_h;
    assign o_event.x      = r_acc_x;
    assign o_event.y      = num_val;

endmodule

[dv/goal_report_line_parser_checker.sv]
// ----------------------------------------------------------------------------
// goal report line parser checker
// watches the request, result and timeout write channels, keeps its own copy
// of the line and goal state, and compares every result with its prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module goal_report_line_parser_checker #(
    parameter int VALUE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic             i_is_tick,
    input  logic [7:0]       i_byte_value,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  logic             i_enemy_seen,
    input  logic             i_enemy_front,
    input  grlp_pkg::t_val16 i_enemy_height,
    input  grlp_pkg::t_val16 i_enemy_x,
    input  grlp_pkg::t_val16 i_enemy_y,
    input  logic             i_home_seen,
    input  logic             i_home_front,
    input  grlp_pkg::t_val16 i_home_height,
    input  grlp_pkg::t_val16 i_home_x,
    input  grlp_pkg::t_val16 i_home_y,
    input  logic             i_line_taken,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [31:0]      i_cfg_timeout_ms,
    output int               o_fail_count,
    output int               o_pending
);
    import grlp_pkg::*;

    localparam longint      MAG_LIMIT     = longint'(1) << (VALUE_BITS - 1);
    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam int          GOAL_ENEMY    = 0;
    localparam int          GOAL_HOME     = 1;

    typedef enum logic [1:0] {KIND_NONE, KIND_ENEMY, KIND_HOME} t_kind;
    typedef enum logic [1:0] {NUM_LEAD, NUM_SIGN, NUM_DIGITS, NUM_DONE} t_num_phase;

    typedef struct packed {
        t_goal enemy;
        t_goal home;
        logic  taken;
    } t_goal_view;

    // goal store
    logic [31:0]        limit_ms;
    logic [31:0]        clock_ms;
    logic               seen       [2];
    logic               front_flag [2];
    logic signed [31:0] stored_val [2][3];
    logic [31:0]        stamp_ms   [2];

    // line being gathered
    logic [2:0]         len_count;
    logic [2:0]         comma_count;
    t_kind              kind;
    logic               text_ended;
    logic               orient_decided;
    logic               orient_front;
    logic               num_neg;
    t_num_phase         num_phase;
    logic [31:0]        magnitude;
    logic signed [31:0] partial [3];

    t_goal_view goal_view_q [$];
    t_goal_view want;
    int         fail_total = 0;
    int         waiting    = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = waiting;

    function automatic void clear_line();
        len_count      = '0;
        comma_count    = '0;
        kind           = KIND_NONE;
        text_ended     = 1'b0;
        orient_decided = 1'b0;
        orient_front   = 1'b0;
        num_neg        = 1'b0;
        num_phase      = NUM_LEAD;
        magnitude      = '0;
        for (int k = 0; k < 3; k++) partial[k] = '0;
    endfunction

    task automatic reset_model();
        limit_ms = TIMEOUT_RESET;
        clock_ms = '0;
        for (int g = 0; g < 2; g++) begin
            seen[g]       = 1'b0;
            front_flag[g] = 1'b0;
            stamp_ms[g]   = '0;
            for (int k = 0; k < 3; k++) stored_val[g][k] = '0;
        end
        clear_line();
    endtask

    // clamp to the signed range; a negative magnitude is already capped at the limit
    function automatic logic signed [31:0] number_now();
        longint v;
        if (num_neg)
            v = -longint'(magnitude);
        else if (longint'(magnitude) < MAG_LIMIT)
            v = longint'(magnitude);
        else
            v = MAG_LIMIT - 1;
        return v[31:0];
    endfunction

    function automatic void number_feed(input logic [7:0] c);
        longint m;
        if (num_phase == NUM_DONE) return;
        if (c >= CH_0 && c <= CH_9) begin
            m = longint'(magnitude) * 10 + longint'(c - CH_0);
            magnitude = (m > MAG_LIMIT) ? MAG_LIMIT[31:0] : m[31:0];
            num_phase = NUM_DIGITS;
        end else if (num_phase == NUM_LEAD && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            num_phase = NUM_LEAD;
        end else if (num_phase == NUM_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
            if (c == CH_MINUS) num_neg = 1'b1;
            num_phase = NUM_SIGN;
        end else begin
            num_phase = NUM_DONE;
        end
    endfunction

    function automatic void line_feed(input logic [7:0] c);
        if (len_count == 3'd0)
            kind = (c == CH_E) ? KIND_ENEMY : ((c == CH_H) ? KIND_HOME : KIND_NONE);
        if (len_count < LEN_MIN) len_count = len_count + 3'd1;
        if (text_ended) return;
        if (c == CH_NUL) begin
            text_ended = 1'b1;
            return;
        end
        if (comma_count == 3'd1 && !orient_decided) begin
            orient_decided = 1'b1;
            orient_front   = (c == CH_F);
        end
        if (c == CH_COMMA && comma_count < FIELD_LAST) begin
            if (comma_count >= 3'd2) partial[comma_count - 3'd2] = number_now();
            comma_count = comma_count + 3'd1;
            magnitude   = '0;
            num_neg     = 1'b0;
            num_phase   = NUM_LEAD;
            return;
        end
        if (comma_count >= 3'd2) number_feed(c);
    endfunction

    function automatic logic line_finish();
        logic ok;
        int   g;
        ok = len_count >= LEN_MIN && kind != KIND_NONE && comma_count == FIELD_LAST;
        if (ok) begin
            g = (kind == KIND_ENEMY) ? GOAL_ENEMY : GOAL_HOME;
            partial[2]    = number_now();
            seen[g]       = 1'b1;
            front_flag[g] = orient_front;
            for (int k = 0; k < 3; k++) stored_val[g][k] = partial[k];
            stamp_ms[g]   = clock_ms;
        end
        clear_line();
        return ok;
    endfunction

    function automatic t_goal goal_face(input int g);
        t_goal f;
        f.seen   = seen[g];
        f.front  = seen[g] && front_flag[g];
        f.height = t_val16'(stored_val[g][0][15:0]);
        f.x      = t_val16'(stored_val[g][1][15:0]);
        f.y      = t_val16'(stored_val[g][2][15:0]);
        return f;
    endfunction

    function automatic t_goal_view step_goal_view(input logic is_tick, input logic [7:0] c);
        t_goal_view  v;
        logic        taken;
        logic [31:0] age;
        taken = 1'b0;
        if (is_tick)
            clock_ms = clock_ms + 32'd1;
        else if (c == CH_LF)
            taken = line_finish();
        else
            line_feed(c);
        // age check on every request, after any line has been stored
        for (int g = 0; g < 2; g++) begin
            age = clock_ms - stamp_ms[g];
            if (seen[g] && age > limit_ms) seen[g] = 1'b0;
        end
        v.enemy = goal_face(GOAL_ENEMY);
        v.home  = goal_face(GOAL_HOME);
        v.taken = taken;
        return v;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            goal_view_q.delete();
        end else begin
            // results first: a result never belongs to a request taken at this edge
            if (i_res_valid && i_res_ready) begin
                if (goal_view_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_total++;
                end else begin
                    want = goal_view_q.pop_front();
                    check_field("enemy_seen",   want.enemy.seen,   i_enemy_seen);
                    check_field("enemy_front",  want.enemy.front,  i_enemy_front);
                    check_field("enemy_height", want.enemy.height, i_enemy_height);
                    check_field("enemy_x",      want.enemy.x,      i_enemy_x);
                    check_field("enemy_y",      want.enemy.y,      i_enemy_y);
                    check_field("home_seen",    want.home.seen,    i_home_seen);
                    check_field("home_front",   want.home.front,   i_home_front);
                    check_field("home_height",  want.home.height,  i_home_height);
                    check_field("home_x",       want.home.x,       i_home_x);
                    check_field("home_y",       want.home.y,       i_home_y);
                    check_field("line_taken",   want.taken,        i_line_taken);
                end
            end
            if (i_cfg_valid && i_cfg_ready) limit_ms = i_cfg_timeout_ms;
            if (i_req_valid && i_req_ready)
                goal_view_q.push_back(step_goal_view(i_is_tick, i_byte_value));
        end
        waiting = goal_view_q.size();
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// goal report line parser testbench
// drives report lines, millisecond ticks and stray bytes into the parser with
// random stalls on both channels, walks the timeout through several values,
// and lets the checker beside the block judge every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import grlp_pkg::*;

    localparam int         VALUE_BITS  = 16;
    localparam logic       FUNC_BYTE   = 1'b0;
    localparam logic       FUNC_TICK   = 1'b1;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam int         PHASE_ITEMS = 170;
    localparam int         NUM_PHASES  = 7;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        i_func           = FUNC_BYTE;
    logic [7:0]  i_byte_value     = 8'h00;
    logic        i_ready          = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic [31:0] i_cfg_timeout_ms = 32'd0;

    logic   o_ready;
    logic   o_valid;
    logic   o_enemy_seen;
    logic   o_enemy_front;
    t_val16 o_enemy_height;
    t_val16 o_enemy_x;
    t_val16 o_enemy_y;
    logic   o_home_seen;
    logic   o_home_front;
    t_val16 o_home_height;
    t_val16 o_home_x;
    t_val16 o_home_y;
    logic   o_line_taken;
    logic   o_cfg_ready;

    int fail_count;
    int pending;

    // handshakes seen at the last rising edge, read back at the falling edge
    logic req_fire = 1'b0;
    logic cfg_fire = 1'b0;

    // no idling on either side once this is set
    logic calm = 1'b0;

    int         sent_total = 0;
    logic [7:0] line_buf [$];

    goal_report_line_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_byte_value     (i_byte_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_enemy_seen     (o_enemy_seen),
        .o_enemy_front    (o_enemy_front),
        .o_enemy_height   (o_enemy_height),
        .o_enemy_x        (o_enemy_x),
        .o_enemy_y        (o_enemy_y),
        .o_home_seen      (o_home_seen),
        .o_home_front     (o_home_front),
        .o_home_height    (o_home_height),
        .o_home_x         (o_home_x),
        .o_home_y         (o_home_y),
        .o_line_taken     (o_line_taken),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_timeout_ms (i_cfg_timeout_ms)
    );

    goal_report_line_parser_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) u_goal_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_is_tick        (i_func == FUNC_TICK),
        .i_byte_value     (i_byte_value),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_enemy_seen     (o_enemy_seen),
        .i_enemy_front    (o_enemy_front),
        .i_enemy_height   (o_enemy_height),
        .i_enemy_x        (o_enemy_x),
        .i_enemy_y        (o_enemy_y),
        .i_home_seen      (o_home_seen),
        .i_home_front     (o_home_front),
        .i_home_height    (o_home_height),
        .i_home_x         (o_home_x),
        .i_home_y         (o_home_y),
        .i_line_taken     (o_line_taken),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_timeout_ms (i_cfg_timeout_ms),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        req_fire <= i_valid && o_ready;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts between ready stretches
    initial begin
        forever begin
            @(negedge i_clk);
            if (calm) begin
                i_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                // now and then a long stretch with no stall at all
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(40, 120)) @(negedge i_clk);
                else
                    repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // one request; valid stays high on return so back-to-back requests keep it up
    task automatic send_request(input logic func, input logic [7:0] b);
        i_valid      <= 1'b1;
        i_func       <= func;
        i_byte_value <= b;
        do @(negedge i_clk); while (req_fire !== 1'b1);
        sent_total++;
    endtask

    // sender idle burst, skipped in the calm part
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    task automatic send_line();
        foreach (line_buf[k]) begin
            maybe_pause();
            send_request(FUNC_BYTE, line_buf[k]);
        end
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        foreach (s[k]) line_buf.push_back(s[k]);
        send_line();
    endtask

    // hold off the sender until every outstanding request has its result
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        i_cfg_valid      <= 1'b1;
        i_cfg_timeout_ms <= value;
        do @(negedge i_clk); while (cfg_fire !== 1'b1);
        i_cfg_valid      <= 1'b0;
    endtask

    // any byte but a newline, so the line is not cut short
    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_LF) ? CH_SPACE : b;
    endfunction

    // number field in atol style: blanks, a sign, digits, maybe trailing junk
    task automatic push_number();
        logic [7:0] blanks [5];
        logic [7:0] junk;
        int         ndig;
        blanks = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        if ($urandom_range(0, 99) < 10) return;                  // empty field
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 2)) line_buf.push_back(blanks[$urandom_range(0, 4)]);
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CH_PLUS);
            1: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        // mostly short numbers, some long enough to saturate
        ndig = ($urandom_range(0, 99) < 20) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        repeat (ndig) line_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 99) < 10) begin
            junk = 8'($urandom_range(8'h21, 8'h7E));
            line_buf.push_back((junk == CH_COMMA) ? CH_SPACE : junk);
        end
    endtask

    // a report line with random content, a quarter of them broken on purpose
    task automatic compose_line();
        int r;
        line_buf.delete();
        r = $urandom_range(0, 99);
        line_buf.push_back((r < 45) ? CH_E : ((r < 90) ? CH_H : stray_byte()));
        line_buf.push_back(CH_COMMA);
        r = $urandom_range(0, 99);
        if (r < 50)
            line_buf.push_back(CH_F);
        else if (r >= 70)
            repeat ($urandom_range(1, 2)) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        line_buf.push_back(CH_COMMA);
        push_number();
        line_buf.push_back(CH_COMMA);
        push_number();
        line_buf.push_back(CH_COMMA);
        push_number();
        if ($urandom_range(0, 99) < 25) begin
            case ($urandom_range(0, 3))
                // lose a byte, possibly a comma or the type
                0: line_buf.delete($urandom_range(0, line_buf.size() - 1));
                // commas beyond the fourth end the y number
                1: begin
                    line_buf.push_back(CH_COMMA);
                    line_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
                end
                // a zero byte hides the rest of the line
                2: line_buf.insert($urandom_range(0, line_buf.size()), CH_NUL);
                default: line_buf.insert($urandom_range(0, line_buf.size()), stray_byte());
            endcase
        end
        line_buf.push_back(CH_LF);
    endtask

    task automatic random_phase(input int count);
        int start;
        int r;
        start = sent_total;
        while (sent_total - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                compose_line();
                send_line();
            end else if (r < 85) begin
                // tick runs, now and then long enough to age a goal out
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 6))
                begin
                    maybe_pause();
                    send_request(FUNC_TICK, 8'($urandom_range(0, 255)));
                end
            end else begin
                // stray bytes, sometimes a bare newline
                repeat ($urandom_range(1, 3)) begin
                    maybe_pause();
                    if ($urandom_range(0, 4) == 0)
                        send_request(FUNC_BYTE, CH_LF);
                    else
                        send_request(FUNC_BYTE, 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        logic [31:0] timeouts [NUM_PHASES];
        timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'($urandom_range(4, 40)),
                     32'd1000, 32'($urandom)};
        // reset held from the start, released at a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: saturation both ways with front, a tick, then all fields empty
        send_text("E,F,99999,-99999,7\n");
        send_request(FUNC_TICK, 8'hFF);
        send_text("H,,,,\n");

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            write_timeout(timeouts[p]);
            if (p == NUM_PHASES - 1) calm = 1'b1;
            random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
